>>> src/hpq_pkg.sv
// ----------------------------------------------------------------------------
// hpq_pkg
// Shared types and constants of the binary max-heap priority queue.
// ----------------------------------------------------------------------------
package hpq_pkg;

   localparam int DEPTH_DEFAULT     = 64;
   localparam int ID_BITS_DEFAULT   = 8;
   localparam int PRIO_BITS_DEFAULT = 8;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      RSP_INSERTED = 2'd0,
      RSP_FULL     = 2'd1,
      RSP_REMOVED  = 2'd2,
      RSP_EMPTY    = 2'd3
   } rsp_code_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_RM_RD,
      ST_RM_CAP,
      ST_DN_RD,
      ST_DN_CMP,
      ST_WR_CUR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic         ins_load;
      logic         code_load;
      rsp_code_type code;
      logic         addr_rm;
      logic         addr_up;
      logic         rm_cap;
      logic         up_move;
      logic         dn_move;
      logic         wr_cur;
      logic         rsp_load;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic parent_zero;
      logic up_greater;
      logic lc_in;
      logic dn_greater;
      logic rsp_free;
   } stat_type;

endpackage

>>> src/hpq_ctrl.sv
// ----------------------------------------------------------------------------
// hpq_ctrl
// Sequencer for insert / remove: steps the datapath through sift up or
// sift down one heap level at a time, then hands the result out.
// ----------------------------------------------------------------------------
module hpq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_kind,
   input  hpq_pkg::stat_type stat,
   output logic              req_ready,
   output hpq_pkg::cmd_type  cmd
);

   hpq_pkg::state_type state_ff, state_in;
   logic               accept;

   assign req_ready = (state_ff == hpq_pkg::ST_IDLE) && !reset;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hpq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hpq_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_kind == hpq_pkg::REQ_INSERT) begin
                  if (stat.full) begin
                     state_in = hpq_pkg::ST_DONE;
                  end else if (stat.empty) begin
                     state_in = hpq_pkg::ST_WR_CUR;
                  end else begin
                     state_in = hpq_pkg::ST_UP_RD;
                  end
               end else begin
                  state_in = stat.empty ? hpq_pkg::ST_DONE : hpq_pkg::ST_RM_RD;
               end
            end
         end
         hpq_pkg::ST_UP_RD:  state_in = hpq_pkg::ST_UP_CMP;
         hpq_pkg::ST_UP_CMP: begin
            if (stat.up_greater && !stat.parent_zero) begin
               state_in = hpq_pkg::ST_UP_RD;
            end else begin
               state_in = hpq_pkg::ST_WR_CUR;
            end
         end
         hpq_pkg::ST_RM_RD:  state_in = hpq_pkg::ST_RM_CAP;
         hpq_pkg::ST_RM_CAP: state_in = hpq_pkg::ST_DN_RD;
         hpq_pkg::ST_DN_RD: begin
            state_in = stat.lc_in ? hpq_pkg::ST_DN_CMP : hpq_pkg::ST_WR_CUR;
         end
         hpq_pkg::ST_DN_CMP: begin
            state_in = stat.dn_greater ? hpq_pkg::ST_DN_RD : hpq_pkg::ST_WR_CUR;
         end
         hpq_pkg::ST_WR_CUR: state_in = hpq_pkg::ST_DONE;
         hpq_pkg::ST_DONE: begin
            if (stat.rsp_free) begin
               state_in = hpq_pkg::ST_IDLE;
            end
         end
         default: state_in = hpq_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.code = hpq_pkg::RSP_INSERTED;
      case (state_ff)
         hpq_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_kind == hpq_pkg::REQ_INSERT) begin
                  if (stat.full) begin
                     cmd.code_load = 1'b1;
                     cmd.code      = hpq_pkg::RSP_FULL;
                  end else begin
                     cmd.ins_load = 1'b1;
                  end
               end else if (stat.empty) begin
                  cmd.code_load = 1'b1;
                  cmd.code      = hpq_pkg::RSP_EMPTY;
               end
            end
         end
         hpq_pkg::ST_UP_RD:  cmd.addr_up = 1'b1;
         hpq_pkg::ST_UP_CMP: cmd.up_move = stat.up_greater;
         hpq_pkg::ST_RM_RD:  cmd.addr_rm = 1'b1;
         hpq_pkg::ST_RM_CAP: cmd.rm_cap  = 1'b1;
         hpq_pkg::ST_DN_RD:  cmd.addr_up = 1'b0;
         hpq_pkg::ST_DN_CMP: cmd.dn_move = stat.dn_greater;
         hpq_pkg::ST_WR_CUR: cmd.wr_cur  = 1'b1;
         hpq_pkg::ST_DONE:   cmd.rsp_load = stat.rsp_free;
         default:            cmd = '0;
      endcase
   end

endmodule

>>> src/hpq_datapath.sv
// ----------------------------------------------------------------------------
// hpq_datapath
// Heap memory, entry count, sifting entry and position, and the result
// output register.
// ----------------------------------------------------------------------------
module hpq_datapath #(
   parameter int DEPTH     = hpq_pkg::DEPTH_DEFAULT,
   parameter int ID_BITS   = hpq_pkg::ID_BITS_DEFAULT,
   parameter int PRIO_BITS = hpq_pkg::PRIO_BITS_DEFAULT,
   localparam int IW       = $clog2(DEPTH),
   localparam int CW       = $clog2(DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  hpq_pkg::cmd_type      cmd,
   input  logic [ID_BITS-1:0]    in_id,
   input  logic [PRIO_BITS-1:0]  in_prio,
   input  logic                  rsp_ready,
   output hpq_pkg::stat_type     stat,
   output logic                  rsp_valid,
   output hpq_pkg::rsp_code_type rsp_code,
   output logic [ID_BITS-1:0]    rsp_id,
   output logic [PRIO_BITS-1:0]  rsp_prio,
   output logic [CW-1:0]         rsp_count
);

   localparam int EW = ID_BITS + PRIO_BITS;

   logic [EW-1:0]         mem [DEPTH];
   logic [EW-1:0]         rd_a_ff, rd_b_ff;
   logic [EW-1:0]         cur_ff;
   logic [IW-1:0]         pos_ff;
   logic [CW-1:0]         count_ff;
   hpq_pkg::rsp_code_type res_code_ff;
   logic [EW-1:0]         res_ent_ff;
   logic                  rsp_valid_ff;
   hpq_pkg::rsp_code_type rsp_code_ff;
   logic [EW-1:0]         rsp_ent_ff;
   logic [CW-1:0]         rsp_count_ff;

   logic [IW-1:0]  parent;
   logic [IW+1:0]  lc_w, rc_w, count_w;
   logic           rc_in, pick_right;
   logic [EW-1:0]  pick_ent;
   logic [IW-1:0]  pick_idx;
   logic [IW-1:0]  addr_a, addr_b;
   logic           we;
   logic [EW-1:0]  wd;

   assign parent     = (pos_ff - 1'b1) >> 1;
   assign lc_w       = {1'b0, pos_ff, 1'b1};
   assign rc_w       = lc_w + 1'b1;
   assign count_w    = (IW + 2)'(count_ff);
   assign rc_in      = rc_w < count_w;
   assign pick_right = rc_in && !(rd_a_ff[PRIO_BITS-1:0] > rd_b_ff[PRIO_BITS-1:0]);
   assign pick_ent   = pick_right ? rd_b_ff : rd_a_ff;
   assign pick_idx   = pick_right ? rc_w[IW-1:0] : lc_w[IW-1:0];

   assign addr_a = cmd.addr_rm ? '0 : (cmd.addr_up ? parent : lc_w[IW-1:0]);
   assign addr_b = cmd.addr_rm ? IW'(count_ff - 1'b1) : rc_w[IW-1:0];

   assign we = cmd.up_move || cmd.dn_move || cmd.wr_cur;
   assign wd = cmd.up_move ? rd_a_ff : (cmd.dn_move ? pick_ent : cur_ff);

   always_ff @(posedge clock) begin
      if (we) begin
         mem[pos_ff] <= wd;
      end
      rd_a_ff <= mem[addr_a];
      rd_b_ff <= mem[addr_b];
   end

   assign stat.full        = (count_ff == CW'(DEPTH));
   assign stat.empty       = (count_ff == '0);
   assign stat.parent_zero = (parent == '0);
   assign stat.up_greater  = cur_ff[PRIO_BITS-1:0] > rd_a_ff[PRIO_BITS-1:0];
   assign stat.lc_in       = lc_w < count_w;
   assign stat.dn_greater  = pick_ent[PRIO_BITS-1:0] > cur_ff[PRIO_BITS-1:0];
   assign stat.rsp_free    = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.ins_load) begin
         count_ff <= count_ff + 1'b1;
      end else if (cmd.rm_cap) begin
         count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ins_load) begin
         cur_ff      <= {in_id, in_prio};
         pos_ff      <= IW'(count_ff);
         res_code_ff <= hpq_pkg::RSP_INSERTED;
         res_ent_ff  <= '0;
      end else if (cmd.code_load) begin
         res_code_ff <= cmd.code;
         res_ent_ff  <= '0;
      end else if (cmd.rm_cap) begin
         cur_ff      <= rd_b_ff;
         pos_ff      <= '0;
         res_code_ff <= hpq_pkg::RSP_REMOVED;
         res_ent_ff  <= rd_a_ff;
      end else if (cmd.up_move) begin
         pos_ff <= parent;
      end else if (cmd.dn_move) begin
         pos_ff <= pick_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_code_ff  <= res_code_ff;
         rsp_ent_ff   <= res_ent_ff;
         rsp_count_ff <= count_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_code  = rsp_code_ff;
   assign rsp_id    = rsp_ent_ff[EW-1:PRIO_BITS];
   assign rsp_prio  = rsp_ent_ff[PRIO_BITS-1:0];
   assign rsp_count = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("heap count above depth");

   a_ins_count: assert property (@(posedge clock) disable iff (reset)
      cmd.ins_load |=> count_ff == CW'($past(count_ff) + 1'b1))
      else $error("insert did not bump count");

   a_rm_count: assert property (@(posedge clock) disable iff (reset)
      cmd.rm_cap |=> count_ff == CW'($past(count_ff) - 1'b1))
      else $error("remove did not drop count");

   a_zero_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_code_ff != hpq_pkg::RSP_REMOVED) |-> rsp_ent_ff == '0)
      else $error("nonzero payload on non-remove transaction");

endmodule

>>> src/max_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Ready queue kept as a binary max-heap of (id, priority) entries.
// ----------------------------------------------------------------------------
// Request channel (req_*): tuser = request kind (0 insert, 1 remove),
// tdata = id, then priority. Response channel (rsp_*): tuser = status
// (0 inserted, 1 full/dropped, 2 removed, 3 empty), tdata = removed id,
// removed priority, entry count after the operation.
// One response transaction per request transaction, in order.
// Requests are taken one at a time. A full insert or an empty remove goes
// straight to the response. An insert sifts up and a remove reads the root
// and the last entry, then sifts down, moving at most log2(DEPTH) heap
// levels; each ends by writing the sifted entry. Each level costs a
// registered memory read and a compare/move; the heap memory has two read
// ports and one write port. The next request is taken in the cycle after
// the response loads.
// A response waits in the output register while rsp_tready is low; the next
// request is accepted meanwhile, and its result waits for the register.
// Synchronous reset empties the heap (count to zero), drops any pending
// response and holds req_tready low; heap memory contents are not cleared.
// ----------------------------------------------------------------------------
module max_heap_priority_queue #(
   parameter int DEPTH       = hpq_pkg::DEPTH_DEFAULT,
   parameter int ID_BITS     = hpq_pkg::ID_BITS_DEFAULT,
   parameter int PRIO_BITS   = hpq_pkg::PRIO_BITS_DEFAULT,
   localparam int CW         = $clog2(DEPTH + 1),
   localparam int REQ_DW     = ((ID_BITS + PRIO_BITS + 7) / 8) * 8,
   localparam int RSP_DW     = ((ID_BITS + PRIO_BITS + CW + 7) / 8) * 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [REQ_DW-1:0] req_tdata,   // proc_id, priority_req
   input  logic              req_tuser,   // req_type
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_DW-1:0] rsp_tdata,   // out_id, out_priority, entry_count
   output logic [1:0]        rsp_tuser    // status
);

   hpq_pkg::cmd_type      cmd;
   hpq_pkg::stat_type     stat;
   hpq_pkg::rsp_code_type rsp_code;
   logic [ID_BITS-1:0]    rsp_id;
   logic [PRIO_BITS-1:0]  rsp_prio;
   logic [CW-1:0]         rsp_count;

   hpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_kind  (req_tuser),
      .stat      (stat),
      .req_ready (req_tready),
      .cmd       (cmd)
   );

   hpq_datapath #(
      .DEPTH     (DEPTH),
      .ID_BITS   (ID_BITS),
      .PRIO_BITS (PRIO_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .in_id     (req_tdata[ID_BITS-1:0]),
      .in_prio   (req_tdata[ID_BITS+PRIO_BITS-1:ID_BITS]),
      .rsp_ready (rsp_tready),
      .stat      (stat),
      .rsp_valid (rsp_tvalid),
      .rsp_code  (rsp_code),
      .rsp_id    (rsp_id),
      .rsp_prio  (rsp_prio),
      .rsp_count (rsp_count)
   );

   assign rsp_tdata = RSP_DW'({rsp_count, rsp_prio, rsp_id});
   assign rsp_tuser = rsp_code;

endmodule

>>> tb/sv/tb_max_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// tb_max_heap_priority_queue
// Self-checking bench for the heap-based ready queue. Requests walk a
// directed table, then randomized fill, drain, tie-heavy and mixed phases.
// The bench keeps its own heap model. Each response transaction is checked
// against the oldest predicted answer. The sender bursts and the receiver
// stalls at random, with long receiver holds that back the block up.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_max_heap_priority_queue;

   localparam int QUEUE_DEPTH  = hpq_pkg::DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES  = 300;
   localparam int NUM_ROWS     = 23;
   localparam int NUM_PHASES   = 4;

   typedef struct packed {
      hpq_pkg::rsp_code_type status;
      logic [7:0]            rid;
      logic [7:0]            rprio;
      logic [6:0]            count;
   } queue_answer_type;

   typedef struct packed {
      logic             kind;
      logic [7:0]       id;
      logic [7:0]       prio;
      logic             typed;
      queue_answer_type answer;
   } plan_row_type;

   typedef enum logic [1:0] {
      RDY_ALWAYS,
      RDY_COIN,
      RDY_SPARSE,
      RDY_MOSTLY
   } ready_mode_type;

   localparam queue_answer_type NO_ANSWER = '{hpq_pkg::RSP_INSERTED, 8'h00, 8'h00, 7'd0};

   // kind, id, prio, typed, answer (status, id, prio, count)
   localparam plan_row_type PLAN_ROWS [NUM_ROWS] = '{
      '{hpq_pkg::REQ_REMOVE, 8'h00, 8'h00, 1'b1, '{hpq_pkg::RSP_EMPTY, 8'h00, 8'h00, 7'd0}},
      '{hpq_pkg::REQ_INSERT, 8'h00, 8'h00, 1'b1, '{hpq_pkg::RSP_INSERTED, 8'h00, 8'h00, 7'd1}},
      '{hpq_pkg::REQ_REMOVE, 8'hFF, 8'hFF, 1'b1, '{hpq_pkg::RSP_REMOVED, 8'h00, 8'h00, 7'd0}},
      '{hpq_pkg::REQ_REMOVE, 8'h00, 8'h00, 1'b1, '{hpq_pkg::RSP_EMPTY, 8'h00, 8'h00, 7'd0}},
      '{hpq_pkg::REQ_INSERT, 8'hFF, 8'hFF, 1'b1, '{hpq_pkg::RSP_INSERTED, 8'h00, 8'h00, 7'd1}},
      '{hpq_pkg::REQ_INSERT, 8'h55, 8'hAA, 1'b1, '{hpq_pkg::RSP_INSERTED, 8'h00, 8'h00, 7'd2}},
      '{hpq_pkg::REQ_INSERT, 8'hAA, 8'h55, 1'b1, '{hpq_pkg::RSP_INSERTED, 8'h00, 8'h00, 7'd3}},
      '{hpq_pkg::REQ_REMOVE, 8'h00, 8'h00, 1'b1, '{hpq_pkg::RSP_REMOVED, 8'hFF, 8'hFF, 7'd2}},
      '{hpq_pkg::REQ_INSERT, 8'h01, 8'h0A, 1'b0, NO_ANSWER},
      '{hpq_pkg::REQ_INSERT, 8'h02, 8'h0A, 1'b0, NO_ANSWER},
      '{hpq_pkg::REQ_INSERT, 8'h03, 8'h0A, 1'b0, NO_ANSWER},
      '{hpq_pkg::REQ_INSERT, 8'h04, 8'h0A, 1'b0, NO_ANSWER},
      '{hpq_pkg::REQ_INSERT, 8'h05, 8'h0B, 1'b0, NO_ANSWER},
      '{hpq_pkg::REQ_INSERT, 8'h06, 8'h0A, 1'b0, NO_ANSWER},
      '{hpq_pkg::REQ_REMOVE, 8'h5A, 8'hA5, 1'b0, NO_ANSWER},
      '{hpq_pkg::REQ_REMOVE, 8'h00, 8'h00, 1'b0, NO_ANSWER},
      '{hpq_pkg::REQ_REMOVE, 8'h00, 8'h00, 1'b0, NO_ANSWER},
      '{hpq_pkg::REQ_REMOVE, 8'h00, 8'h00, 1'b0, NO_ANSWER},
      '{hpq_pkg::REQ_REMOVE, 8'h00, 8'h00, 1'b0, NO_ANSWER},
      '{hpq_pkg::REQ_REMOVE, 8'h00, 8'h00, 1'b0, NO_ANSWER},
      '{hpq_pkg::REQ_REMOVE, 8'h00, 8'h00, 1'b0, NO_ANSWER},
      '{hpq_pkg::REQ_REMOVE, 8'h00, 8'h00, 1'b0, NO_ANSWER},
      '{hpq_pkg::REQ_REMOVE, 8'h00, 8'h00, 1'b1, '{hpq_pkg::RSP_EMPTY, 8'h00, 8'h00, 7'd0}}
   };

   // fill, drain, ties, mixed
   localparam int PHASE_ITEMS    [NUM_PHASES] = '{110, 110, 110, 97};
   localparam int PHASE_INS_PCT  [NUM_PHASES] = '{85, 15, 50, 60};
   localparam int PHASE_PRIO_MAX [NUM_PHASES] = '{255, 255, 3, 7};
   localparam bit PHASE_HOLD     [NUM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0};

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // proc_id, priority_req
   logic        req_tuser  = hpq_pkg::REQ_INSERT;   // req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;   // out_id, out_priority, entry_count
   logic [1:0]  rsp_tuser;   // status

   logic [7:0]       model_id   [QUEUE_DEPTH];
   logic [7:0]       model_prio [QUEUE_DEPTH];
   int unsigned      model_count = 0;
   queue_answer_type pending_answers [$];
   int               error_count = 0;
   int unsigned      cycle_count = 0;
   bit               hold_off_req = 1'b0;
   int unsigned      hold_left = 0;
   int unsigned      mode_left = 0;
   int unsigned      sparse_phase = 0;
   ready_mode_type   ready_mode = RDY_ALWAYS;

   max_heap_priority_queue dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void swap_slots(input int unsigned a, input int unsigned b);
      logic [7:0] t_id;
      logic [7:0] t_prio;
      t_id          = model_id[a];
      t_prio        = model_prio[a];
      model_id[a]   = model_id[b];
      model_prio[a] = model_prio[b];
      model_id[b]   = t_id;
      model_prio[b] = t_prio;
   endfunction

   function automatic queue_answer_type heap_model_apply(input logic kind,
                                                         input logic [7:0] id,
                                                         input logic [7:0] prio);
      queue_answer_type ans;
      int unsigned      pos;
      int unsigned      left;
      int unsigned      right;
      int unsigned      pick;
      bit               moving;
      ans = NO_ANSWER;
      if (kind == hpq_pkg::REQ_INSERT) begin
         if (model_count >= QUEUE_DEPTH) begin
            ans.status = hpq_pkg::RSP_FULL;
         end else begin
            pos = model_count;
            model_id[pos]   = id;
            model_prio[pos] = prio;
            model_count++;
            while (pos > 0 && model_prio[pos] > model_prio[(pos - 1) / 2]) begin
               swap_slots(pos, (pos - 1) / 2);
               pos = (pos - 1) / 2;
            end
            ans.status = hpq_pkg::RSP_INSERTED;
         end
      end else if (model_count == 0) begin
         ans.status = hpq_pkg::RSP_EMPTY;
      end else begin
         ans.status = hpq_pkg::RSP_REMOVED;
         ans.rid    = model_id[0];
         ans.rprio  = model_prio[0];
         model_id[0]   = model_id[model_count - 1];
         model_prio[0] = model_prio[model_count - 1];
         model_count--;
         pos    = 0;
         moving = 1'b1;
         while (moving) begin
            left  = 2 * pos + 1;
            right = left + 1;
            if (left >= model_count) begin
               moving = 1'b0;
            end else begin
               // ties between children go right
               if (right < model_count && !(model_prio[left] > model_prio[right]))
                  pick = right;
               else
                  pick = left;
               if (model_prio[pick] > model_prio[pos]) begin
                  swap_slots(pick, pos);
                  pos = pick;
               end else begin
                  moving = 1'b0;
               end
            end
         end
      end
      ans.count = 7'(model_count);
      return ans;
   endfunction

   task automatic send_request(input logic kind, input logic [7:0] id,
                               input logic [7:0] prio, input logic typed,
                               input queue_answer_type typed_answer);
      queue_answer_type predicted;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {prio, id};
      do @(posedge clock); while (!req_tready);
      predicted = heap_model_apply(kind, id, prio);
      pending_answers.push_back(typed ? typed_answer : predicted);
   endtask

   // sender
   initial begin
      int unsigned burst_left;
      int unsigned gap;
      logic        kind;
      burst_left = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int r = 0; r < NUM_ROWS; r++) begin
         send_request(PLAN_ROWS[r].kind, PLAN_ROWS[r].id, PLAN_ROWS[r].prio,
                      PLAN_ROWS[r].typed, PLAN_ROWS[r].answer);
      end
      for (int p = 0; p < NUM_PHASES; p++) begin
         if (PHASE_HOLD[p])
            hold_off_req = 1'b1;
         for (int i = 0; i < PHASE_ITEMS[p]; i++) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20)
                                                 : $urandom_range(1, 3);
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end else begin
               burst_left--;
            end
            kind = ($urandom_range(0, 99) < PHASE_INS_PCT[p]) ? hpq_pkg::REQ_INSERT
                                                                : hpq_pkg::REQ_REMOVE;
            send_request(kind, 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, PHASE_PRIO_MAX[p])), 1'b0, NO_ANSWER);
         end
      end
      req_tvalid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // receiver: random stall modes, plus long holds on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_off_req) begin
         hold_off_req = 1'b0;
         hold_left    = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode = ready_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(20, 120);
         end else begin
            mode_left--;
         end
         sparse_phase = (sparse_phase + 1) % 5;
         case (ready_mode)
            RDY_ALWAYS: rsp_tready <= 1'b1;
            RDY_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
            RDY_SPARSE: rsp_tready <= (sparse_phase == 0);
            default:    rsp_tready <= ($urandom_range(0, 9) != 0);
         endcase
      end
   end

   // response checker
   always @(posedge clock) begin
      queue_answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_answers.size() == 0) begin
            $error("unexpected response transaction: status %0d data %h",
                   rsp_tuser, rsp_tdata);
            error_count++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata[7:0] !== want.rid) begin
               $error("out_id: expected %0d, got %0d", want.rid, rsp_tdata[7:0]);
               error_count++;
            end
            if (rsp_tdata[15:8] !== want.rprio) begin
               $error("out_priority: expected %0d, got %0d", want.rprio, rsp_tdata[15:8]);
               error_count++;
            end
            if (rsp_tdata[22:16] !== want.count) begin
               $error("entry_count: expected %0d, got %0d", want.count, rsp_tdata[22:16]);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

endmodule
